### rtl/core/laplacian_flux_stencil_core_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef LAPLACIAN_FLUX_STENCIL_CORE_DEFINES_SVH
`define LAPLACIAN_FLUX_STENCIL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lfs_pkg.sv
package lfs_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumRows  = 5;
  localparam int unsigned WinCols  = 4;
  localparam int unsigned NumCols  = WinCols + 1;
  localparam int unsigned NumLanes = 5;
  // Room for 4*v minus four neighbors without overflow.
  localparam int unsigned LapW     = WordW + 4;
  localparam int unsigned CntW     = 3;

  // Lane roles.
  localparam int unsigned LaneCtr   = 0;
  localparam int unsigned LaneWest  = 1;
  localparam int unsigned LaneEast  = 2;
  localparam int unsigned LaneNorth = 3;
  localparam int unsigned LaneSouth = 4;

  // Center position of each lane's Laplacian inside the five-column snapshot.
  localparam int unsigned LapCol [NumLanes] = '{2, 1, 3, 2, 2};
  localparam int unsigned LapRow [NumLanes] = '{2, 2, 2, 1, 3};

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumRows-1:0][WordW-1:0] col_t;
  typedef col_t [NumCols-1:0] snap_t;
  typedef logic [NumLanes-1:0][WordW-1:0] laps_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    logic valid;
    logic last;
  } seq_ctl_t;

endpackage

### rtl/core/lfs_lap_lane.sv
module lfs_lap_lane (
  input  logic          clk_i,
  input  logic          en_i,
  input  lfs_pkg::word_t center_i,
  input  lfs_pkg::word_t north_i,
  input  lfs_pkg::word_t south_i,
  input  lfs_pkg::word_t west_i,
  input  lfs_pkg::word_t east_i,
  output lfs_pkg::word_t lap_o
);
  import lfs_pkg::*;

  logic signed [LapW-1:0] sum;
  word_t                  lap_d;
  word_t                  lap_q;

  always_comb begin
    sum = (LapW'($signed(center_i)) <<< 2) - LapW'($signed(north_i))
        - LapW'($signed(south_i)) - LapW'($signed(west_i)) - LapW'($signed(east_i));
    // The top bits must all match the sign bit of a 32-bit value.
    if ((&sum[LapW-1:WordW-1]) || !(|sum[LapW-1:WordW-1])) begin
      lap_d = sum[WordW-1:0];
    end else if (sum[LapW-1]) begin
      lap_d = {1'b1, {(WordW-1){1'b0}}};
    end else begin
      lap_d = {1'b0, {(WordW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lap_q <= lap_d;
    end
  end

  assign lap_o = lap_q;

endmodule

### rtl/core/lfs_window.sv
module lfs_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  lfs_pkg::col_t     cur_i,
  input  logic              end_i,
  output logic              in_stall_o,
  input  logic              adv_i,
  output lfs_pkg::snap_t    snap_o,
  output lfs_pkg::seq_ctl_t seq_ctl_o
);
  import lfs_pkg::*;

  col_t  win_q [WinCols];
  col_t  win_d [WinCols];
  cnt_t  seen_q, seen_d;
  cnt_t  rem_q, rem_d;
  logic  end_q, end_d;
  snap_t snap_q, snap_d;

  col_t  cols [NumCols];
  snap_t load;
  cnt_t  count;
  cnt_t  pstart;
  logic  seq_v;
  logic  fire;
  logic  in_ready;
  logic  in_acc;

  assign seq_v    = rem_q != '0;
  assign fire     = seq_v && adv_i;
  assign in_ready = !seq_v || (fire && rem_q == cnt_t'(1));
  assign in_acc   = in_valid_i && in_ready;

  // Columns held before the start of the current row read as zero.
  always_comb begin
    for (int c = 0; c < WinCols; c++) begin
      if (cnt_t'(c) + seen_q >= cnt_t'(WinCols)) begin
        cols[c] = win_q[c];
      end else begin
        cols[c] = '0;
      end
    end
    cols[WinCols] = cur_i;
  end

  // An end item replays every remaining result column, starting at the first
  // column of the row; the snapshot is loaded already shifted to that start.
  always_comb begin
    logic [CntW:0] idx;
    if (end_i) begin
      count  = seen_q + cnt_t'(1);
      pstart = cnt_t'(WinCols) - seen_q;
    end else begin
      count  = (seen_q == cnt_t'(WinCols)) ? cnt_t'(1) : '0;
      pstart = '0;
    end
    for (int j = 0; j < NumCols; j++) begin
      idx = (CntW+1)'(j) + {1'b0, pstart};
      if (idx < (CntW+1)'(NumCols)) begin
        load[j] = cols[idx[CntW-1:0]];
      end else begin
        load[j] = '0;
      end
    end
  end

  always_comb begin
    win_d  = win_q;
    seen_d = seen_q;
    rem_d  = rem_q;
    end_d  = end_q;
    snap_d = snap_q;
    if (fire) begin
      rem_d = rem_q - cnt_t'(1);
      for (int j = 0; j < NumCols - 1; j++) begin
        snap_d[j] = snap_q[j+1];
      end
      snap_d[NumCols-1] = '0;
    end
    if (in_acc) begin
      rem_d = count;
      end_d = end_i;
      if (count != '0) begin
        snap_d = load;
      end
      if (end_i) begin
        seen_d = '0;
      end else begin
        for (int c = 0; c < WinCols - 1; c++) begin
          win_d[c] = win_q[c+1];
        end
        win_d[WinCols-1] = cur_i;
        seen_d = (seen_q == cnt_t'(WinCols)) ? seen_q : seen_q + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      rem_q  <= '0;
      end_q  <= 1'b0;
    end else begin
      seen_q <= seen_d;
      rem_q  <= rem_d;
      end_q  <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    snap_q <= snap_d;
  end

  assign in_stall_o      = !in_ready;
  assign snap_o          = snap_q;
  assign seq_ctl_o.valid = seq_v;
  assign seq_ctl_o.last  = end_q && rem_q == cnt_t'(1);

endmodule

### rtl/core/lfs_merge.sv
module lfs_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfs_pkg::seq_ctl_t seq_ctl_i,
  input  lfs_pkg::laps_t    laps_i,
  output logic              lane_en_o,
  output logic              adv_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lfs_pkg::word_t    flux_west_o,
  output lfs_pkg::word_t    flux_east_o,
  output lfs_pkg::word_t    flux_north_o,
  output lfs_pkg::word_t    flux_south_o,
  output logic              last_result_o
);
  import lfs_pkg::*;

  logic  lane_v_q, lane_v_d;
  logic  lane_last_q, lane_last_d;
  logic  out_v_q, out_v_d;
  logic  out_ready;
  logic  lane_ready;
  word_t west_q, east_q, north_q, south_q;
  logic  last_q;

  assign out_ready  = !out_v_q || !out_stall_i;
  assign lane_ready = !lane_v_q || out_ready;

  always_comb begin
    lane_v_d    = lane_v_q;
    lane_last_d = lane_last_q;
    out_v_d     = out_v_q;
    if (lane_ready) begin
      lane_v_d    = seq_ctl_i.valid;
      lane_last_d = seq_ctl_i.last;
    end
    if (out_ready) begin
      out_v_d = lane_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_v_q    <= 1'b0;
      lane_last_q <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      lane_v_q    <= lane_v_d;
      lane_last_q <= lane_last_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      west_q  <= laps_i[LaneCtr] - laps_i[LaneWest];
      east_q  <= laps_i[LaneEast] - laps_i[LaneCtr];
      north_q <= laps_i[LaneCtr] - laps_i[LaneNorth];
      south_q <= laps_i[LaneSouth] - laps_i[LaneCtr];
      last_q  <= lane_last_q;
    end
  end

  assign lane_en_o     = lane_ready && seq_ctl_i.valid;
  assign adv_o         = lane_ready;
  assign out_valid_o   = out_v_q;
  assign flux_west_o   = west_q;
  assign flux_east_o   = east_q;
  assign flux_north_o  = north_q;
  assign flux_south_o  = south_q;
  assign last_result_o = last_q;

endmodule

### rtl/core/laplacian_flux_stencil_core.sv
// Laplacian flux stencil: each item is one grid column of five rows, and each
// result is the west, east, north and south flux difference for a column two
// places behind the newest one. Columns stream in at one item per clock while
// the output is not stalled; a result passes through the snapshot, lane and
// output registers. An item with end_of_row set emits every pending result of
// the row, one per cycle from the result sequencer while the output is not
// stalled, so it occupies the sequencer for one result more than the number of
// earlier columns in the window (at most five results) and the input is stalled
// until the last one is issued. The five Laplacians of a result are computed by
// five parallel lanes and combined by the output stage.
module laplacian_flux_stencil_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lfs_pkg::WordW-1:0]    row_top_i,
  input  logic signed [lfs_pkg::WordW-1:0]    row_upper_i,
  input  logic signed [lfs_pkg::WordW-1:0]    row_center_i,
  input  logic signed [lfs_pkg::WordW-1:0]    row_lower_i,
  input  logic signed [lfs_pkg::WordW-1:0]    row_bottom_i,
  input  logic                                end_of_row_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lfs_pkg::WordW-1:0]    flux_west_o,
  output logic signed [lfs_pkg::WordW-1:0]    flux_east_o,
  output logic signed [lfs_pkg::WordW-1:0]    flux_north_o,
  output logic signed [lfs_pkg::WordW-1:0]    flux_south_o,
  output logic                                last_result_o
);
  import lfs_pkg::*;

  col_t     cur;
  snap_t    snap;
  seq_ctl_t seq_ctl;
  laps_t    laps;
  logic     lane_en;
  logic     adv;
  word_t    west, east, north, south;

  assign cur = {row_bottom_i, row_lower_i, row_center_i, row_upper_i, row_top_i};

  lfs_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cur_i      (cur),
    .end_i      (end_of_row_i),
    .in_stall_o (in_stall_o),
    .adv_i      (adv),
    .snap_o     (snap),
    .seq_ctl_o  (seq_ctl)
  );

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    localparam int unsigned Cc = LapCol[l];
    localparam int unsigned Rr = LapRow[l];

    lfs_lap_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (lane_en),
      .center_i (snap[Cc][Rr]),
      .north_i  (snap[Cc][Rr-1]),
      .south_i  (snap[Cc][Rr+1]),
      .west_i   (snap[Cc-1][Rr]),
      .east_i   (snap[Cc+1][Rr]),
      .lap_o    (laps[l])
    );
  end

  lfs_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seq_ctl_i     (seq_ctl),
    .laps_i        (laps),
    .lane_en_o     (lane_en),
    .adv_o         (adv),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .flux_west_o   (west),
    .flux_east_o   (east),
    .flux_north_o  (north),
    .flux_south_o  (south),
    .last_result_o (last_result_o)
  );

  assign flux_west_o  = west;
  assign flux_east_o  = east;
  assign flux_north_o = north;
  assign flux_south_o = south;

endmodule

### rtl/core/lfs_checker.sv
`include "laplacian_flux_stencil_core_defines.svh"

module lfs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic signed [lfs_pkg::WordW-1:0] row_top_i,
  input logic signed [lfs_pkg::WordW-1:0] row_upper_i,
  input logic signed [lfs_pkg::WordW-1:0] row_center_i,
  input logic signed [lfs_pkg::WordW-1:0] row_lower_i,
  input logic signed [lfs_pkg::WordW-1:0] row_bottom_i,
  input logic                             end_of_row_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [lfs_pkg::WordW-1:0] flux_west_o,
  input logic signed [lfs_pkg::WordW-1:0] flux_east_o,
  input logic signed [lfs_pkg::WordW-1:0] flux_north_o,
  input logic signed [lfs_pkg::WordW-1:0] flux_south_o,
  input logic                             last_result_o
);

  // A stalled result stays put.
  `LFS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(flux_west_o) && $stable(flux_east_o) && $stable(flux_north_o) && $stable(flux_south_o) && $stable(last_result_o), "stalled result changed")

  // A result rising on an idle output stems from an item taken by the sequencer.
  `LFS_ASSERT_IMPL(a_fresh_latency, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 3), "result appeared without a matching item")

  // The input stall can only start right after an item was taken.
  `LFS_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, $past(in_stall_o) || $past(in_valid_i && !in_stall_o), "input stalled with an empty sequencer")

endmodule

bind laplacian_flux_stencil_core lfs_checker u_lfs_checker (.*);

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lfs_pkg::*;

  localparam word_t WordZero = 32'h0000_0000;
  localparam word_t WordMax  = 32'h7fff_ffff;
  localparam word_t WordMin  = 32'h8000_0000;
  localparam word_t WordOnes = 32'hffff_ffff;

  localparam longint SatHi = 2147483647;
  localparam longint SatLo = -SatHi - 1;

  localparam int unsigned GridCols    = WinCols + 5;
  localparam int unsigned RandItems   = 320;
  localparam int unsigned PhaseLen    = 80;
  localparam int unsigned HoldAfter   = 40;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxPrinted  = 50;

  localparam int IdlePct [4] = '{0, 61, 0, 38};
  localparam int StallPct[4] = '{0, 0, 61, 38};

  typedef struct packed {
    word_t top;
    word_t upper;
    word_t center;
    word_t lower;
    word_t bottom;
    logic  eor;
  } column_t;

  typedef struct packed {
    word_t west;
    word_t east;
    word_t north;
    word_t south;
    logic  last;
  } flux_t;

  typedef struct packed {
    column_t col;
    logic    typed;
    flux_t   want;
  } dir_row_t;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  word_t row_top;
  word_t row_upper;
  word_t row_center;
  word_t row_lower;
  word_t row_bottom;
  logic  end_of_row;
  logic  out_valid;
  logic  out_stall;
  word_t flux_west;
  word_t flux_east;
  word_t flux_north;
  word_t flux_south;
  logic  last_result;

  int          idle_pct;
  int          stall_pct;
  int unsigned error_count;
  int unsigned cycle_count;

  // Shadow copy of the column window and the expected flux results.
  word_t       col_win[WinCols][NumRows];
  int unsigned cols_held;
  longint      lap_grid[GridCols][NumRows];
  flux_t       flux_expected[$];

  laplacian_flux_stencil_core DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .row_top_i    (row_top),
    .row_upper_i  (row_upper),
    .row_center_i (row_center),
    .row_lower_i  (row_lower),
    .row_bottom_i (row_bottom),
    .end_of_row_i (end_of_row),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .flux_west_o  (flux_west),
    .flux_east_o  (flux_east),
    .flux_north_o (flux_north),
    .flux_south_o (flux_south),
    .last_result_o(last_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MaxPrinted) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Five-point Laplacian at row r, column c of the grid, saturated to 32 bits.
  function automatic word_t lap_sat(int r, int c);
    longint s;
    s = 4 * lap_grid[c][r] - lap_grid[c][r-1] - lap_grid[c][r+1]
        - lap_grid[c-1][r] - lap_grid[c+1][r];
    if (s > SatHi) s = SatHi;
    if (s < SatLo) s = SatLo;
    return s[31:0];
  endfunction

  function automatic void push_flux(int p, logic last);
    word_t ctr, lw, le, ln, ls;
    flux_t f;
    ctr = lap_sat(2, p + 2);
    lw  = lap_sat(2, p + 1);
    le  = lap_sat(2, p + 3);
    ln  = lap_sat(1, p + 2);
    ls  = lap_sat(3, p + 2);
    f.west  = ctr - lw;
    f.east  = le - ctr;
    f.north = ctr - ln;
    f.south = ls - ctr;
    f.last  = last;
    flux_expected.push_back(f);
  endfunction

  function automatic void predict_column(column_t col);
    word_t cur[NumRows];
    cur = '{col.top, col.upper, col.center, col.lower, col.bottom};
    foreach (lap_grid[c, r]) lap_grid[c][r] = 0;
    for (int c = 0; c < WinCols; c++)
      for (int r = 0; r < NumRows; r++) lap_grid[c][r] = $signed(col_win[c][r]);
    for (int r = 0; r < NumRows; r++) lap_grid[WinCols][r] = $signed(cur[r]);
    if (col.eor) begin
      // The end item flushes every pending column; columns past the end are zero.
      for (int p = WinCols - cols_held; p <= WinCols; p++) push_flux(p, p == WinCols);
      foreach (col_win[c, r]) col_win[c][r] = '0;
      cols_held = 0;
    end else begin
      if (cols_held == WinCols) push_flux(0, 1'b0);
      for (int c = 0; c < WinCols - 1; c++)
        for (int r = 0; r < NumRows; r++) col_win[c][r] = col_win[c+1][r];
      for (int r = 0; r < NumRows; r++) col_win[WinCols-1][r] = cur[r];
      if (cols_held < WinCols) cols_held++;
    end
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(9))
      0: return WordMax;
      1: return WordMin;
      2: return WordZero;
      3: return WordOnes;
      4, 5: return word_t'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic column_t rand_column(logic eor);
    column_t c;
    c.top    = rand_word();
    c.upper  = rand_word();
    c.center = rand_word();
    c.lower  = rand_word();
    c.bottom = rand_word();
    c.eor    = eor;
    return c;
  endfunction

  // Offers one item, holds it until accepted, then records what it should produce.
  task automatic send_column(column_t col, logic typed, flux_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    {row_top, row_upper, row_center, row_lower, row_bottom, end_of_row} <= col;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_column(col);
    if (typed) begin
      void'(flux_expected.pop_back());
      flux_expected.push_back(want);
    end
  endtask

  task automatic check_word(string name, word_t got, word_t want);
    if (got !== want) report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  task automatic check_result();
    flux_t got, want;
    got = {flux_west, flux_east, flux_north, flux_south, last_result};
    if (flux_expected.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: %h", got));
    end else begin
      want = flux_expected.pop_front();
      check_word("flux_west", got.west, want.west);
      check_word("flux_east", got.east, want.east);
      check_word("flux_north", got.north, want.north);
      check_word("flux_south", got.south, want.south);
      check_word("last_result", word_t'(got.last), word_t'(want.last));
    end
  endtask

  initial begin : result_sink
    int unsigned n_checked;
    logic        held_once;
    n_checked = 0;
    held_once = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_result();
        n_checked++;
      end
      if (!held_once && n_checked == HoldAfter) begin
        // Long back-pressure while the sender keeps going, so the block fills up.
        held_once = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    dir_row_t    dir_tab[$];
    int unsigned rand_sent;
    int unsigned row_len;
    int unsigned phase;
    logic        broken;
    logic        eor;

    idle_pct    = 0;
    stall_pct   = 0;
    error_count = 0;
    cols_held   = 0;
    foreach (col_win[c, r]) col_win[c][r] = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    {row_top, row_upper, row_center, row_lower, row_bottom, end_of_row} <= '0;

    // Single-column rows: only the west flux sees the center value.
    dir_tab.push_back('{column_t'{WordZero, WordZero, WordZero, WordZero, WordZero, 1'b1},
                        1'b1, flux_t'{WordZero, WordZero, WordZero, WordZero, 1'b1}});
    dir_tab.push_back('{column_t'{WordMax, WordMin, WordMax, WordMin, WordMax, 1'b1},
                        1'b1, flux_t'{WordMax, WordZero, WordZero, WordZero, 1'b1}});
    dir_tab.push_back('{column_t'{WordOnes, WordOnes, WordMin, WordOnes, WordOnes, 1'b1},
                        1'b1, flux_t'{32'h8000_0001, WordZero, WordZero, WordZero, 1'b1}});
    // Short row of three columns.
    dir_tab.push_back('{column_t'{32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 1'b0}, 1'b0, '0});
    dir_tab.push_back('{column_t'{32'hdead_beef, 32'h0123_4567, 32'h89ab_cdef,
                                  32'h5555_5555, 32'haaaa_aaaa, 1'b0}, 1'b0, '0});
    dir_tab.push_back('{column_t'{32'hffff_fff0, 32'h0000_0100, 32'hffff_8000,
                                  32'h7fff_0000, 32'h8000_ffff, 1'b1}, 1'b0, '0});
    // Checkerboard of extremes saturates the Laplacians both ways over a long row.
    for (int c = 0; c < 7; c++) begin
      if (c % 2 == 0)
        dir_tab.push_back('{column_t'{WordMax, WordMin, WordMax, WordMin, WordMax, c == 6},
                            1'b0, '0});
      else
        dir_tab.push_back('{column_t'{WordMin, WordMax, WordMin, WordMax, WordMin, 1'b0},
                            1'b0, '0});
    end
    for (int c = 0; c < 5; c++)
      dir_tab.push_back('{column_t'{WordMin, WordMin, WordMin, WordMin, WordMin, c == 4},
                          1'b0, '0});
    for (int c = 0; c < 4; c++)
      dir_tab.push_back('{column_t'{WordMax, WordMax, WordMax, WordMax, WordMax, c == 3},
                          1'b0, '0});
    dir_tab.push_back('{column_t'{WordOnes, WordOnes, 32'd1, WordOnes, WordOnes, 1'b1},
                        1'b1, flux_t'{32'd1, WordZero, WordZero, WordZero, 1'b1}});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_column(dir_tab[i].col, dir_tab[i].typed, dir_tab[i].want);

    // Mostly complete rows of random length; some rows with end marks at random.
    rand_sent = 0;
    while (rand_sent < RandItems) begin
      row_len = ($urandom_range(9) < 8) ? $urandom_range(12, 1) : $urandom_range(24, 13);
      broken  = ($urandom_range(99) < 15);
      for (int i = 0; i < row_len && rand_sent < RandItems; i++) begin
        phase = rand_sent / PhaseLen;
        if (phase > 3) phase = 3;
        idle_pct  = IdlePct[phase];
        stall_pct = StallPct[phase];
        eor = broken ? ($urandom_range(2) == 0) : (i == row_len - 1);
        if (rand_sent == RandItems - 1) eor = 1'b1;
        send_column(rand_column(eor), 1'b0, '0);
        rand_sent++;
      end
    end

    in_valid  <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (flux_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
